/* sv/rdsm_pkg.sv */
// shared types and constants for the radial distortion source map core
// payload structs, channel codes and register indexes; no dependencies
`default_nettype none
package rdsm_pkg;

   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int DEF_COORD_FRAC_BITS = 8;
   localparam int DEF_COEF_WIDTH      = 16;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_CENTER_X     = 3'd0,
      REG_CENTER_Y     = 3'd1,
      REG_INV_RADIUS   = 3'd2,
      REG_COEF_RED     = 3'd3,
      REG_COEF_GREEN   = 3'd4,
      REG_COEF_BLUE    = 3'd5,
      REG_SRC_ORIGIN_X = 3'd6,
      REG_SRC_ORIGIN_Y = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic [1:0]         channel;
   } req_type;

   typedef struct packed {
      logic signed [15:0] src_x_int;
      logic [7:0]         src_x_frac;
      logic signed [15:0] src_y_int;
      logic [7:0]         src_y_frac;
      logic [1:0]         channel_out;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/radial_distortion_source_map_core.sv */
// radial lens distortion source address generator, fully pipelined
// depends on rdsm_pkg for payload structs, channel codes and register indexes
`default_nettype none
// usage
//   req channel: one beat per destination pixel and colour channel (dest_x,
//   dest_y, channel). rsp channel: one beat per request, in order, with the
//   floor integer source position relative to the window origin (saturated to
//   16 bits) and an 8-bit bilinear fraction per axis, plus the echoed channel.
//   csr port: csr_write with csr_index and csr_wdata writes one register;
//   write only while no beats are in flight.
// throughput and depth
//   one beat per cycle sustained while rsp_stall does not hold a valid response.
//   the pipeline runs from the input registers through the squares and radicand,
//   the radius square root, which retires one root bit per stage, the scale
//   multiply, the radius saturation, three horner multiply/add pairs, the
//   offset multiply, the centre/origin add and the output split.
// reset
//   synchronous, active high: pipeline valids clear, registers go to the
//   identity map (centre 0, scale 0, coefficient d = 1.0, origin 0).
// stall
//   while rsp_stall holds a valid response, every stage freezes together and
//   req_stall is raised; nothing is dropped or repeated.
module radial_distortion_source_map_core
   import rdsm_pkg::*;
#(
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
   parameter int COEF_WIDTH      = DEF_COEF_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int F    = COORD_FRAC_BITS;
   localparam int K    = COEF_WIDTH - 2;
   localparam int P    = F + K;
   // offset from centre, signed QF
   localparam int DW   = ((16 + F > 24) ? 16 + F : 24) + 1;
   // root width and remainder width
   localparam int RW   = DW + 1;
   localparam int REMW = RW + 3;
   localparam int VW   = DW + 34;
   localparam int S_R  = 2 + RW;        // stage holding the finished root
   localparam int NUM_STAGES = S_R + 12;

   // configuration registers
   logic signed [23:0] center_x_ff, center_y_ff;
   logic [31:0]        inv_radius_ff;
   logic [63:0]        coef_red_ff, coef_green_ff, coef_blue_ff;
   logic signed [15:0] origin_x_ff, origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         inv_radius_ff <= '0;
         coef_red_ff   <= 64'd16384;
         coef_green_ff <= 64'd16384;
         coef_blue_ff  <= 64'd16384;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_CENTER_X:     center_x_ff   <= csr_wdata[23:0];
            REG_CENTER_Y:     center_y_ff   <= csr_wdata[23:0];
            REG_INV_RADIUS:   inv_radius_ff <= csr_wdata[31:0];
            REG_COEF_RED:     coef_red_ff   <= csr_wdata;
            REG_COEF_GREEN:   coef_green_ff <= csr_wdata;
            REG_COEF_BLUE:    coef_blue_ff  <= csr_wdata;
            REG_SRC_ORIGIN_X: origin_x_ff   <= csr_wdata[15:0];
            REG_SRC_ORIGIN_Y: origin_y_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // channel three falls to blue
   function automatic logic [63:0] coef_word(input logic [1:0] ch,
                                             input logic [63:0] red,
                                             input logic [63:0] green,
                                             input logic [63:0] blue);
      logic [63:0] w;
      case (ch)
         CH_RED:   w = red;
         CH_GREEN: w = green;
         default:  w = blue;
      endcase
      return w;
   endfunction

   // global advance: whole pipe freezes while the output beat is held
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // per-stage carries
   logic                 vld_ff [NUM_STAGES];
   logic signed [DW-1:0] dx_ff  [NUM_STAGES];
   logic signed [DW-1:0] dy_ff  [NUM_STAGES];
   logic [1:0]           ch_ff  [NUM_STAGES];
   logic [30:0]          rn_ff  [NUM_STAGES];

   logic signed [DW-1:0] dx_in, dy_in;
   assign dx_in = (DW'(req_data.dest_x) <<< F) - DW'(center_x_ff);
   assign dy_in = (DW'(req_data.dest_y) <<< F) - DW'(center_y_ff);

   // normalized radius, unsigned Q.16, saturated
   logic [RW+31:0] rprod_ff;
   logic [RW+31:0] rshift;
   logic [30:0]    rn_in;
   assign rshift = rprod_ff >> (F + 16);
   assign rn_in  = (rshift > (RW+32)'(31'h7fffffff)) ? 31'h7fffffff : rshift[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NUM_STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff[0] <= dx_in;
         dy_ff[0] <= dy_in;
         ch_ff[0] <= req_data.channel;
         rn_ff[0] <= '0;
         for (int i = 1; i < NUM_STAGES; i++) begin
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
            ch_ff[i] <= ch_ff[i-1];
            rn_ff[i] <= (i == S_R + 2) ? rn_in : rn_ff[i-1];
         end
      end
   end

   // squares and radicand
   logic [DW-1:0]     adx, ady;
   logic [2*DW-1:0]   sqx_ff, sqy_ff;
   logic [2*RW-1:0]   rad0_ff;
   assign adx = dx_ff[0][DW-1] ? DW'(-dx_ff[0]) : DW'(dx_ff[0]);
   assign ady = dy_ff[0][DW-1] ? DW'(-dy_ff[0]) : DW'(dy_ff[0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff  <= adx * adx;
         sqy_ff  <= ady * ady;
         rad0_ff <= (2*RW)'(sqx_ff) + (2*RW)'(sqy_ff);
      end
   end

   // square root, one root bit per stage
   logic [2*RW-1:0] sq_rad_ff  [RW];
   logic [REMW-1:0] sq_rem_ff  [RW];
   logic [RW-1:0]   sq_root_ff [RW];

   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      logic [2*RW-1:0] rad_prev;
      logic [REMW-1:0] rem_prev, rem_sh, trial;
      logic [RW-1:0]   root_prev;
      if (g == 0) begin : g_first
         assign rad_prev  = rad0_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_rest
         assign rad_prev  = sq_rad_ff[g-1];
         assign rem_prev  = sq_rem_ff[g-1];
         assign root_prev = sq_root_ff[g-1];
      end
      assign rem_sh = {rem_prev[REMW-3:0], rad_prev[2*RW-1 -: 2]};
      assign trial  = REMW'({root_prev, 2'b01});
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rad_ff[g] <= rad_prev << 2;
            if (rem_sh >= trial) begin
               sq_rem_ff[g]  <= rem_sh - trial;
               sq_root_ff[g] <= {root_prev[RW-2:0], 1'b1};
            end else begin
               sq_rem_ff[g]  <= rem_sh;
               sq_root_ff[g] <= {root_prev[RW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rprod_ff <= (RW+32)'(sq_root_ff[RW-1]) * (RW+32)'(inv_radius_ff);
   end

   // horner steps: multiply stage then floor/add/saturate stage
   logic signed [63:0] hp_ff   [3];
   logic signed [31:0] hacc_ff [3];

   for (genvar j = 0; j < 3; j++) begin : g_horner
      localparam int SP = S_R + 3 + 2*j;
      logic signed [31:0] acc_src, rn_s, coef_add;
      logic [63:0]        wa;
      logic signed [63:0] sh, sum;
      assign wa = coef_word(ch_ff[SP], coef_red_ff, coef_green_ff, coef_blue_ff);
      if (j == 0) begin : g_a
         logic [63:0] wp;
         assign wp      = coef_word(ch_ff[SP-1], coef_red_ff, coef_green_ff,
                                    coef_blue_ff);
         assign acc_src = 32'(signed'(wp[3*COEF_WIDTH +: COEF_WIDTH]));
      end else begin : g_acc
         assign acc_src = hacc_ff[j-1];
      end
      assign rn_s     = signed'({1'b0, rn_ff[SP-1]});
      assign coef_add = 32'(signed'(wa[(2-j)*COEF_WIDTH +: COEF_WIDTH]));
      assign sh       = hp_ff[j] >>> 16;
      assign sum      = sh + 64'(coef_add);
      always_ff @(posedge clock) begin
         if (adv) begin
            hp_ff[j] <= 64'(acc_src) * 64'(rn_s);
            if (sum > 64'sh7fffffff)
               hacc_ff[j] <= 32'sh7fffffff;
            else if (sum < -64'sh80000000)
               hacc_ff[j] <= 32'sh80000000;
            else
               hacc_ff[j] <= sum[31:0];
         end
      end
   end

   // scale offset, add centre back, remove origin, split
   logic signed [DW+31:0] vxp_ff, vyp_ff;
   logic signed [VW-1:0]  vx_ff, vy_ff;
   logic signed [VW-1:0]  qx, qy;
   rsp_type               rsp_data_ff;

   function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] q);
      logic signed [15:0] r;
      if (q > VW'(32767))       r = 16'sh7fff;
      else if (q < -VW'(32768)) r = 16'sh8000;
      else                      r = q[15:0];
      return r;
   endfunction

   assign qx = vx_ff >>> P;
   assign qy = vy_ff >>> P;

   always_ff @(posedge clock) begin
      if (adv) begin
         vxp_ff <= (DW+32)'(dx_ff[S_R+8]) * (DW+32)'(hacc_ff[2]);
         vyp_ff <= (DW+32)'(dy_ff[S_R+8]) * (DW+32)'(hacc_ff[2]);
         vx_ff  <= VW'(vxp_ff) + (VW'(center_x_ff) <<< K) - (VW'(origin_x_ff) <<< P);
         vy_ff  <= VW'(vyp_ff) + (VW'(center_y_ff) <<< K) - (VW'(origin_y_ff) <<< P);
         rsp_data_ff.src_x_int   <= sat16(qx);
         rsp_data_ff.src_x_frac  <= vx_ff[P-1 -: 8];
         rsp_data_ff.src_y_int   <= sat16(qy);
         rsp_data_ff.src_y_frac  <= vy_ff[P-1 -: 8];
         rsp_data_ff.channel_out <= ch_ff[NUM_STAGES-2];
      end
   end

   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
